/* hw/rtl/lsvm_pkg.sv */
// Shared types, constants and the gain table of the looping sample voice mixer.
package lsvm_pkg;

  localparam int SMP_W  = 16;
  localparam int IDX_W  = 14;
  localparam int LEN_W  = 15;
  localparam int VSEL_W = 3;
  localparam int MASK_W = 8;
  localparam int CNT_W  = 4;
  localparam int GAIN_W = 16;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MIX  = 1'b1;

  localparam logic signed [SMP_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SAT_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_base;
    logic smp_vld;
  } mac_ctrl_t;

  // Q1.15 gain, about 1/n for n touched voices
  function automatic logic [GAIN_W-1:0] gain_lookup(input logic [CNT_W-1:0] cnt);
    logic [GAIN_W-1:0] g;
    case (cnt)
      4'd1:    g = 16'd32768;
      4'd2:    g = 16'd16384;
      4'd3:    g = 16'd10912;
      4'd4:    g = 16'd8192;
      4'd5:    g = 16'd6554;
      4'd6:    g = 16'd5439;
      4'd7:    g = 16'd4653;
      4'd8:    g = 16'd4063;
      default: g = 16'd0;
    endcase
    return g;
  endfunction

endpackage

/* hw/rtl/lsvm_if.sv */
// Input and result channel interfaces of the looping sample voice mixer.
interface lsvm_in_if;
  import lsvm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [VSEL_W-1:0]       voice;
  logic [IDX_W-1:0]        sample_index;
  logic signed [SMP_W-1:0] sample_value;
  logic                    sample_last;
  logic                    buffer_start;
  logic [MASK_W-1:0]       touched_any_mask;
  logic [MASK_W-1:0]       touched_full_mask;
  logic signed [SMP_W-1:0] base_left;

  modport source (
    output valid, req_type, voice, sample_index, sample_value, sample_last,
           buffer_start, touched_any_mask, touched_full_mask, base_left,
    input  ready
  );
  modport sink (
    input  valid, req_type, voice, sample_index, sample_value, sample_last,
           buffer_start, touched_any_mask, touched_full_mask, base_left,
    output ready
  );
endinterface

interface lsvm_out_if;
  import lsvm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] mixed_left;
  logic signed [SMP_W-1:0] mixed_right;

  modport source (output valid, mixed_left, mixed_right, input ready);
  modport sink (input valid, mixed_left, mixed_right, output ready);
endinterface

/* hw/rtl/lsvm_sample_mem.sv */
// Sample memory: one write port, one read port with registered read data.
module lsvm_sample_mem #(
  parameter int AW = 17
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [lsvm_pkg::SMP_W-1:0] wdata,
  input  logic                             re,
  input  logic [AW-1:0]                    raddr,
  output logic signed [lsvm_pkg::SMP_W-1:0] rdata
);
  import lsvm_pkg::*;

  logic signed [SMP_W-1:0] mem [1 << AW];
  logic signed [SMP_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* hw/rtl/lsvm_mac.sv */
// Multiply by the mix gain, truncate toward zero and accumulate with saturation.
module lsvm_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lsvm_pkg::mac_ctrl_t               ctrl,
  input  logic signed [lsvm_pkg::SMP_W-1:0]  base,
  input  logic signed [lsvm_pkg::SMP_W-1:0]  sample,
  input  logic [lsvm_pkg::GAIN_W-1:0]       gain,
  output logic signed [lsvm_pkg::SMP_W-1:0]  acc,
  output logic                              busy
);
  import lsvm_pkg::*;

  logic signed [SMP_W+GAIN_W:0] prod;
  logic signed [SMP_W+GAIN_W:0] prod_r;
  logic                         mul_v_r;
  logic signed [SMP_W-1:0]      acc_r;
  logic signed [SMP_W+1:0]      quot;
  logic signed [SMP_W+1:0]      sum;
  logic signed [SMP_W-1:0]      acc_nxt;
  logic                         round_up;

  assign prod = sample * $signed({1'b0, gain});

  // shift floors; bump negative values with a nonzero remainder toward zero
  assign round_up = prod_r[SMP_W+GAIN_W] && (|prod_r[14:0]);
  assign quot     = (SMP_W+2)'(prod_r >>> 15) + (SMP_W+2)'(round_up);
  assign sum      = (SMP_W+2)'(acc_r) + quot;

  always_comb begin
    if (sum > (SMP_W+2)'(SAT_MAX)) begin
      acc_nxt = SAT_MAX;
    end else if (sum < (SMP_W+2)'(SAT_MIN)) begin
      acc_nxt = SAT_MIN;
    end else begin
      acc_nxt = sum[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else begin
      mul_v_r <= ctrl.smp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.smp_vld) begin
      prod_r <= prod;
    end
    if (ctrl.load_base) begin
      acc_r <= base;
    end else if (mul_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc  = acc_r;
  assign busy = mul_v_r;
endmodule

/* hw/rtl/looping_sample_voice_mixer.sv */
// Eight-voice looping sample mixer: top level with sequencer and voice state.
//
// Channels: in_if carries load and mix transactions, out_if carries one mixed
// frame per mix transaction; a load returns nothing.
// A load writes the sample, scaled by 3/4, to the voice's sample memory when
// the voice and index are in range; the last word sets the voice length and
// rewinds it. A mix walks the voices one per cycle, with one sample memory
// read for each fully touched voice of nonzero length, then drains the
// multiply/accumulate pipeline and places the frame in the output register.
// The next transaction is taken in the same cycle as the frame appears on
// out_if.
// The single read port of the sample memory sets the per-voice cycle.
// The output register holds a finished frame while the receiver stalls; the
// block keeps taking transactions and only waits to hand over the next frame.
// Reset clears lengths, positions, latched masks and gain; sample memory
// contents are undefined until loaded.
module looping_sample_voice_mixer #(
  parameter int VOICES     = 8,
  parameter int MAX_FRAMES = 16384
) (
  input logic        clk,
  input logic        rst_n,
  lsvm_in_if.sink    in_if,
  lsvm_out_if.source out_if
);
  import lsvm_pkg::*;

  localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int FW  = $clog2(MAX_FRAMES);
  localparam int AW  = VIW + FW;

  state_t state_r, state_nxt;
  logic [VIW-1:0] k_r, k_nxt;
  logic           rd_v_r;
  logic           out_valid_r;
  logic signed [SMP_W-1:0] out_left_r;

  logic [VOICES-1:0] any_r;
  logic [VOICES-1:0] full_r;
  logic [GAIN_W-1:0] gain_r;
  logic [LEN_W-1:0]  len_r [VOICES];
  logic [IDX_W-1:0]  pos_r [VOICES];

  logic in_fire, mix_fire, load_fire, load_ok;
  logic issue, last_k, done_fire, mac_busy;
  logic [LEN_W-1:0] len_k;
  logic [IDX_W-1:0] pos_k, pos_eff, pos_next;
  logic [LEN_W-1:0] pos_inc;
  logic [AW-1:0]    raddr, waddr;
  logic signed [SMP_W+1:0] s_ext, s_x3, s_adj;
  logic signed [SMP_W-1:0] scaled, rdata, acc;
  mac_ctrl_t mac_ctrl;

  assign in_fire   = in_if.valid && in_if.ready;
  assign mix_fire  = in_fire && (in_if.req_type == REQ_MIX);
  assign load_fire = in_fire && (in_if.req_type == REQ_LOAD);
  assign load_ok   = ({29'd0, in_if.voice} < 32'(VOICES)) &&
                     ({18'd0, in_if.sample_index} < 32'(MAX_FRAMES));

  // scale by 3/4, truncated toward zero
  assign s_ext  = (SMP_W+2)'(in_if.sample_value);
  assign s_x3   = (s_ext <<< 1) + s_ext;
  assign s_adj  = s_x3 + ((s_x3 < 0) ? (SMP_W+2)'(3) : (SMP_W+2)'(0));
  assign scaled = s_adj[SMP_W+1:2];
  assign waddr  = {in_if.voice[VIW-1:0], FW'(in_if.sample_index)};

  // voice under service this cycle
  assign len_k    = len_r[k_r];
  assign pos_k    = pos_r[k_r];
  assign pos_eff  = ((LEN_W'(pos_k)) >= len_k) ? '0 : pos_k;
  assign pos_inc  = LEN_W'(pos_eff) + LEN_W'(1);
  assign pos_next = (pos_inc >= len_k) ? '0 : pos_inc[IDX_W-1:0];
  assign raddr    = {k_r, FW'(pos_eff)};
  assign last_k   = (k_r == VIW'(VOICES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (mix_fire) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_k) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + VIW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !mac_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_if.ready = 1'b0;
    issue       = 1'b0;
    done_fire   = 1'b0;
    case (state_r)
      ST_IDLE:  in_if.ready = 1'b1;
      ST_RUN:   issue = full_r[k_r] && (len_k != '0);
      ST_DRAIN: ;
      ST_DONE:  done_fire = !out_valid_r || out_if.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      any_r       <= '0;
      full_r      <= '0;
      gain_r      <= '0;
      for (int i = 0; i < VOICES; i++) begin
        len_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      rd_v_r  <= issue;
      // hold the frame until taken, load the next one on hand-over
      out_valid_r <= done_fire || (out_valid_r && !out_if.ready);
      if (mix_fire && in_if.buffer_start) begin
        any_r  <= in_if.touched_any_mask[VOICES-1:0];
        full_r <= in_if.touched_full_mask[VOICES-1:0];
        gain_r <= gain_lookup(CNT_W'($countones(in_if.touched_any_mask[VOICES-1:0])));
      end
      if (load_fire && load_ok && in_if.sample_last) begin
        len_r[in_if.voice[VIW-1:0]] <= LEN_W'(in_if.sample_index) + LEN_W'(1);
        pos_r[in_if.voice[VIW-1:0]] <= '0;
      end
      if (state_r == ST_RUN) begin
        if (full_r[k_r]) begin
          pos_r[k_r] <= (len_k == '0) ? '0 : pos_next;
        end else if (!any_r[k_r]) begin
          pos_r[k_r] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_left_r <= acc;
    end
  end

  assign mac_ctrl.load_base = mix_fire;
  assign mac_ctrl.smp_vld   = rd_v_r;

  lsvm_sample_mem #(
    .AW(AW)
  ) u_mem (
    .clk   (clk),
    .we    (load_fire && load_ok),
    .waddr (waddr),
    .wdata (scaled),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  lsvm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .base   (in_if.base_left),
    .sample (rdata),
    .gain   (gain_r),
    .acc    (acc),
    .busy   (mac_busy)
  );

  assign out_if.valid       = out_valid_r;
  assign out_if.mixed_left  = out_left_r;
  assign out_if.mixed_right = out_left_r;
endmodule

/* hw/rtl/lsvm_checker.sv */
// Port-level checks of the looping sample voice mixer, bound to the top level.
module lsvm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [lsvm_pkg::SMP_W-1:0]       mixed_left,
  input logic [lsvm_pkg::SMP_W-1:0]       mixed_right
);
  import lsvm_pkg::*;

  // a frame never shows up the cycle after any transaction into an empty output
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared one cycle after a transaction");

  a_right_mirrors_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (mixed_right == mixed_left))
    else $error("right channel differs from left");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(mixed_left)))
    else $error("stalled result changed");
endmodule

bind looping_sample_voice_mixer lsvm_checker u_lsvm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .mixed_left  (out_if.mixed_left),
  .mixed_right (out_if.mixed_right)
);
